>>> src/fir_filter_five_tap_defines.svh
// assertion macros for the five tap fir filter
`ifndef FIR_FILTER_FIVE_TAP_DEFINES_SVH
`define FIR_FILTER_FIVE_TAP_DEFINES_SVH

// consequent holds in the same cycle
`define FIR5_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the next cycle
`define FIR5_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/fir5_pkg.sv
// shared types and constants of the five tap fir filter
package fir5_pkg;

	localparam int SampleW = 16;
	localparam int CoefW   = 16;
	localparam int ProdW   = SampleW + CoefW;
	localparam int NumCoef = 5;

	localparam logic [2:0] COEF_COUNT = 3'(NumCoef);

	typedef logic signed [SampleW-1:0] sample_t;
	typedef logic signed [CoefW-1:0]   coef_t;
	typedef logic signed [ProdW-1:0]   prod_t;

	localparam coef_t COEF_RESET [NumCoef] = '{
		16'sd1108, 16'sd7868, 16'sd14818, 16'sd7868, 16'sd1108
	};

	typedef struct packed {
		logic       vld;
		logic       last;
		logic       ent_vld;
		logic [2:0] k;
	} rd_ctl_t;

endpackage

>>> src/fir5_ram.sv
// generic single write port, single read port ram with registered read
module fir5_ram #(
	parameter int W = 16,
	parameter int D = 5
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                    wdata,
	input  logic                            re,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                    rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/fir_filter_five_tap.sv
// five tap fir filter: top level with delay line ram and one shared multiply-accumulate
// an accepted beat runs the tap reads in ST_RUN, the registered ram read and ctl_s1,
//   prod_s2, acc_q and the ST_OUT load of out_q; no new beat is taken until that load;
//   one tap read per cycle from the delay line ram's single read port, one multiplier
// reset: arst_n clears control, write pointer and the per-entry valid bits, so the delay
//   line reads as zeros, and loads the coefficient reset values; no clearing pass
`include "fir_filter_five_tap_defines.svh"

module fir_filter_five_tap #(
	parameter int TAPS = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [15:0] sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [15:0] filtered,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW   = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int AccW = fir5_pkg::ProdW + AW + 1;
	localparam int Frac = 15;

	localparam logic [AW-1:0] PTR_LAST = AW'(TAPS - 1);
	localparam logic [2:0]    K_LAST   = 3'(TAPS - 1);

	localparam logic signed [AccW-1:0] SAT_HI = AccW'(32767);
	localparam logic signed [AccW-1:0] SAT_LO = AccW'(-32768);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]          st_q;
	logic [AW-1:0]       wp_q;
	logic [AW-1:0]       rd_ptr_q;
	logic [2:0]          k_q;
	logic [TAPS-1:0]     ent_vld_q;
	fir5_pkg::coef_t     coef_q [fir5_pkg::NumCoef];

	fir5_pkg::rd_ctl_t   ctl_s1;
	logic                vld_s2;
	logic                last_s2;
	fir5_pkg::prod_t     prod_s2;
	logic signed [AccW-1:0] acc_q;

	logic                out_vld_q;
	fir5_pkg::sample_t   out_q;

	logic                in_acc;
	logic                out_take;
	logic                out_load;
	logic [15:0]         ram_rdata;
	fir5_pkg::sample_t   tap_val;
	fir5_pkg::coef_t     tap_coef;
	logic signed [AccW-1:0] acc_bias;
	logic signed [AccW-1:0] acc_quot;
	fir5_pkg::sample_t   sat_val;

	assign in_stall  = (st_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_take  = out_vld_q && !out_stall;
	assign out_load  = (st_q == ST_OUT) && (!out_vld_q || !out_stall);
	assign cfg_ready = 1'b1;
	assign out_valid = out_vld_q;
	assign filtered  = out_q;

	fir5_ram #(
		.W(16),
		.D(TAPS)
	) u_dly_ram (
		.clk   (clk),
		.we    (in_acc),
		.waddr (wp_q),
		.wdata (sample),
		.re    (st_q == ST_RUN),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fir5_pkg::NumCoef; i++) begin
				coef_q[i] <= fir5_pkg::COEF_RESET[i];
			end
		end else if (cfg_valid && cfg_ready && (cfg_index < fir5_pkg::COEF_COUNT)) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			wp_q      <= '0;
			rd_ptr_q  <= '0;
			k_q       <= '0;
			ent_vld_q <= '0;
			ctl_s1    <= '0;
			vld_s2    <= 1'b0;
			last_s2   <= 1'b0;
		end else begin
			ctl_s1.vld <= (st_q == ST_RUN);
			vld_s2     <= ctl_s1.vld;
			last_s2    <= ctl_s1.vld && ctl_s1.last;
			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						ent_vld_q[wp_q] <= 1'b1;
						rd_ptr_q        <= wp_q;
						wp_q            <= (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
						k_q             <= '0;
						st_q            <= ST_RUN;
					end
				end
				ST_RUN: begin
					ctl_s1.last    <= (k_q == K_LAST);
					ctl_s1.ent_vld <= ent_vld_q[rd_ptr_q];
					ctl_s1.k       <= k_q;
					k_q            <= k_q + 1'b1;
					rd_ptr_q       <= (rd_ptr_q == '0) ? PTR_LAST : rd_ptr_q - 1'b1;
					if (k_q == K_LAST) begin
						st_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (vld_s2 && last_s2) begin
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// tap select: unwritten entries read as zero, taps past the registers weigh zero
	assign tap_val  = ctl_s1.ent_vld ? ram_rdata : '0;
	assign tap_coef = (ctl_s1.k < fir5_pkg::COEF_COUNT) ? coef_q[ctl_s1.k] : '0;

	always_ff @(posedge clk) begin
		if (ctl_s1.vld) begin
			prod_s2 <= tap_val * tap_coef;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + {{(AccW-fir5_pkg::ProdW){prod_s2[fir5_pkg::ProdW-1]}}, prod_s2};
		end
	end

	// divide by 2^15 rounding toward zero, then saturate
	always_comb begin
		acc_bias = acc_q + {{(AccW-Frac){1'b0}}, {Frac{acc_q[AccW-1]}}};
		acc_quot = acc_bias >>> Frac;
		priority if (acc_quot > SAT_HI) begin
			sat_val = 16'sh7fff;
		end else if (acc_quot < SAT_LO) begin
			sat_val = 16'sh8000;
		end else begin
			sat_val = acc_quot[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= sat_val;
		end
	end

	`FIR5_ASSERT_NEXT(a_accept_starts_run, in_acc, st_q == ST_RUN, "accepted beat did not start tap reads")
	`FIR5_ASSERT_NEXT(a_load_sets_valid, out_load, out_vld_q, "result load did not raise out_valid")
	`FIR5_ASSERT_NOW(a_no_mac_when_idle, vld_s2 || ctl_s1.vld, st_q == ST_RUN || st_q == ST_WAIT, "tap in flight outside run or wait")
	`FIR5_ASSERT_NOW(a_tap_in_range, st_q == ST_RUN, k_q <= K_LAST, "tap index past last tap")
	`FIR5_ASSERT_NEXT(a_last_tap_to_out, vld_s2 && last_s2, st_q == ST_OUT, "last product did not lead to output")

endmodule
